### sv/lft_pkg.sv
// shared types, constants and saturation helpers for the leg frame translation core
// no dependencies; used by lft_sine_lane, lft_merge and leg_frame_translation_core
`default_nettype none
package lft_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_THIGH = 2'd0;
   localparam logic [1:0] REG_SHIN  = 2'd1;
   localparam logic [1:0] REG_FOOT  = 2'd2;

   localparam logic [13:0] THIGH_RESET = 14'd4000;
   localparam logic [13:0] SHIN_RESET  = 14'd4000;
   localparam logic [12:0] FOOT_RESET  = 13'd1000;

   // odd series coefficients of sin(pi/2 * z), Q30
   localparam logic [30:0] SIN_C1 = 31'd1686629713;
   localparam logic [29:0] SIN_C3 = 30'd693598668;
   localparam logic [26:0] SIN_C5 = 27'd85569306;
   localparam logic [22:0] SIN_C7 = 23'd5026995;

   // floor(2^36 / 1125), reciprocal for the quarter angle scaling
   localparam logic [25:0] RECIP_1125 = 26'd61083979;
   localparam logic [10:0] DIV_1125   = 11'd1125;
   localparam logic [25:0] ROUND_HALF = 26'd562;

   localparam logic signed [16:0] HIP_Y_OFFSET = -17'sd2400;
   localparam logic signed [23:0] POS_LIMIT    = 24'sd100000;
   localparam logic signed [23:0] SHIFT_MAX    = 24'sd2097151;
   localparam logic signed [23:0] SHIFT_MIN    = -24'sd2097152;

   // item fields that ride alongside the lanes
   typedef struct packed {
      logic               mode;
      logic               swing_right;
      logic signed [17:0] tip;
      logic signed [17:0] foothold;
      logic signed [17:0] obs_y;
      logic signed [17:0] obs_z;
   } side_type;

   function automatic logic signed [17:0] sat_pos(input logic signed [23:0] v);
      logic signed [23:0] c;
      c = v;
      if (v > POS_LIMIT) c = POS_LIMIT;
      else if (v < -POS_LIMIT) c = -POS_LIMIT;
      return c[17:0];
   endfunction

   function automatic logic signed [21:0] sat_shift(input logic signed [23:0] v);
      logic signed [23:0] c;
      c = v;
      if (v > SHIFT_MAX) c = SHIFT_MAX;
      else if (v < SHIFT_MIN) c = SHIFT_MIN;
      return c[21:0];
   endfunction

endpackage
`default_nettype wire

### sv/lft_sine_lane.sv
// one lane: angle reduction, Q1.15 sine by odd polynomial, scaled by a link length
// depends on lft_pkg for coefficients
`default_nettype none
module lft_sine_lane (
   input  wire logic               clock,
   input  wire logic [8:0]         en,
   input  wire logic signed [17:0] angle,
   input  wire logic [13:0]        link_len,
   output logic signed [14:0]      proj
);

   logic signed [18:0] a_ext, r19;
   logic [15:0]        r;
   logic [13:0]        x;
   logic               neg;

   logic [13:0] x1_ff;
   logic [6:0]  neg_ff;
   logic [25:0] m2_ff;
   logic [15:0] q0_ff, z3_ff, z4_ff, z5_ff, z6_ff, z7_ff;
   logic [15:0] z2_4_ff, z2_5_ff, z2_6_ff;
   logic [26:0] p5_ff;
   logic [29:0] p3_ff;
   logic [30:0] p1_ff;
   logic signed [15:0] sine_ff;
   logic signed [14:0] proj_ff;

   logic [25:0] m_in;
   logic [51:0] recip_prod;
   logic [26:0] qm, rem;
   logic [15:0] z_in;
   logic [31:0] zz;
   logic [47:0] prod5, prod6, prod7, prod8;
   logic [32:0] s_val;
   logic [32:0] s_rnd;
   logic [17:0] q_mag;
   logic [15:0] q_sat;
   logic signed [30:0] lprod, lsum;

   // reduce into [0, 36000) and fold into a quarter
   always_comb begin
      a_ext = {angle[17], angle};
      if (a_ext < 0) begin
         if (a_ext + 19'sd36000 >= 0) r19 = a_ext + 19'sd36000;
         else r19 = a_ext + 19'sd72000;
      end else if (a_ext >= 19'sd72000) begin
         r19 = a_ext - 19'sd72000;
      end else if (a_ext >= 19'sd36000) begin
         r19 = a_ext - 19'sd36000;
      end else begin
         r19 = a_ext;
      end
      r = r19[15:0];
      if (r <= 16'd9000) begin
         x = r[13:0]; neg = 1'b0;
      end else if (r <= 16'd18000) begin
         x = 14'(16'd18000 - r); neg = 1'b0;
      end else if (r <= 16'd27000) begin
         x = 14'(r - 16'd18000); neg = 1'b1;
      end else begin
         x = 14'(16'd36000 - r); neg = 1'b1;
      end
   end

   always_comb begin
      m_in       = {x1_ff, 12'd0} + lft_pkg::ROUND_HALF;
      recip_prod = 52'(m_in) * 52'(lft_pkg::RECIP_1125);
      qm         = 27'(q0_ff) * 27'(lft_pkg::DIV_1125);
      rem        = {1'b0, m2_ff} - qm;
      z_in       = (rem >= 27'(lft_pkg::DIV_1125)) ? q0_ff + 16'd1 : q0_ff;
      zz         = 32'(z3_ff) * 32'(z3_ff);
      prod5      = 48'(lft_pkg::SIN_C7) * 48'(z2_4_ff);
      prod6      = 48'(p5_ff) * 48'(z2_5_ff);
      prod7      = 48'(p3_ff) * 48'(z2_6_ff);
      prod8      = 48'(p1_ff) * 48'(z7_ff);
      s_val      = prod8[47:15];
      s_rnd      = s_val + 33'd16384;
      q_mag      = s_rnd[32:15];
      q_sat      = (q_mag > 18'd32767) ? 16'd32767 : q_mag[15:0];
      lprod      = $signed({1'b0, link_len}) * sine_ff;
      lsum       = lprod + 31'sd16384;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x1_ff     <= x;
         neg_ff[0] <= neg;
      end
      if (en[1]) begin
         m2_ff     <= m_in;
         q0_ff     <= recip_prod[51:36];
         neg_ff[1] <= neg_ff[0];
      end
      if (en[2]) begin
         z3_ff     <= z_in;
         neg_ff[2] <= neg_ff[1];
      end
      if (en[3]) begin
         z4_ff     <= z3_ff;
         z2_4_ff   <= zz[30:15];
         neg_ff[3] <= neg_ff[2];
      end
      if (en[4]) begin
         z5_ff     <= z4_ff;
         z2_5_ff   <= z2_4_ff;
         p5_ff     <= 27'(48'(lft_pkg::SIN_C5) - (prod5 >> 15));
         neg_ff[4] <= neg_ff[3];
      end
      if (en[5]) begin
         z6_ff     <= z5_ff;
         z2_6_ff   <= z2_5_ff;
         p3_ff     <= 30'(48'(lft_pkg::SIN_C3) - (prod6 >> 15));
         neg_ff[5] <= neg_ff[4];
      end
      if (en[6]) begin
         z7_ff     <= z6_ff;
         p1_ff     <= 31'(48'(lft_pkg::SIN_C1) - (prod7 >> 15));
         neg_ff[6] <= neg_ff[5];
      end
      if (en[7]) begin
         sine_ff   <= neg_ff[6] ? -$signed(q_sat) : $signed(q_sat);
      end
      if (en[8]) begin
         proj_ff   <= lsum[29:15];
      end
   end

   assign proj = proj_ff;

endmodule
`default_nettype wire

### sv/lft_merge.sv
// merging stages: heel placement, swing heel frame, saturation and the latched y shift
// depends on lft_pkg for side_type and saturation helpers
`default_nettype none
module lft_merge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [2:0]            en,
   input  wire logic                  m2_valid,
   input  wire logic [7:0][14:0]      lane_proj,
   input  wire lft_pkg::side_type     side,
   input  wire logic [12:0]           foot_len,
   output logic signed [17:0]         foothold_out,
   output logic [14:0]                hip_height,
   output logic signed [17:0]         pivot_y,
   output logic signed [17:0]         obstacle_y_out,
   output logic signed [17:0]         obstacle_z_out,
   output logic                       swing_right
);

   lft_pkg::side_type side1_ff, side2_ff;
   logic signed [16:0] heel_l_ff, heel_r_ff, drop_l_ff, drop_r_ff;
   logic signed [18:0] center_ff;
   logic signed [19:0] d1_ff;
   logic signed [20:0] d2_ff;
   logic signed [17:0] pivot_ff;
   logic [14:0]        hh_ff;
   logic signed [21:0] shift_ff, shift_in;

   logic signed [16:0] heel_l, heel_r, drop_l, drop_r;
   logic signed [16:0] sw_y, sp_y, sw_d, sp_d;
   logic signed [19:0] d1;
   logic signed [20:0] d2;
   logic signed [17:0] hsum;
   logic [14:0]        hh;
   logic signed [23:0] fo_wide, sh_wide, oy_wide;

   always_comb begin
      heel_l = lft_pkg::HIP_Y_OFFSET + 17'($signed(lane_proj[0]))
               + 17'($signed(lane_proj[1]));
      drop_l = 17'($signed(lane_proj[2])) + 17'($signed(lane_proj[3]));
      heel_r = lft_pkg::HIP_Y_OFFSET + 17'($signed(lane_proj[4]))
               + 17'($signed(lane_proj[5]));
      drop_r = 17'($signed(lane_proj[6])) + 17'($signed(lane_proj[7]));
   end

   always_comb begin
      if (side1_ff.swing_right) begin
         sw_y = heel_r_ff; sw_d = drop_r_ff; sp_y = heel_l_ff; sp_d = drop_l_ff;
      end else begin
         sw_y = heel_l_ff; sw_d = drop_l_ff; sp_y = heel_r_ff; sp_d = drop_r_ff;
      end
      d1   = 20'(center_ff) - 20'(sp_y);
      d2   = 21'(d1) + 21'(sw_y);
      hsum = 18'(sw_d) + 18'(sp_d);
      // halve, negative sums read as zero height, large sums clamp to 32767
      if (hsum < 0) hh = 15'd0;
      else if (hsum[17:1] > 17'sd32767) hh = 15'd32767;
      else hh = hsum[15:1];
   end

   always_comb begin
      fo_wide  = 24'(side2_ff.foothold) - 24'(d2_ff);
      sh_wide  = 24'(d1_ff) + 24'(d2_ff);
      oy_wide  = 24'(side2_ff.obs_y) - 24'(shift_ff);
      shift_in = shift_ff;
      if (m2_valid && en[2] && !side2_ff.mode) shift_in = lft_pkg::sat_shift(sh_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else begin
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side1_ff  <= side;
         heel_l_ff <= heel_l;
         heel_r_ff <= heel_r;
         drop_l_ff <= drop_l;
         drop_r_ff <= drop_r;
         center_ff <= 19'(side.tip) - 19'($signed({1'b0, foot_len}));
      end
      if (en[1]) begin
         side2_ff <= side1_ff;
         d1_ff    <= d1;
         d2_ff    <= d2;
         pivot_ff <= lft_pkg::sat_pos(24'(sp_y) - 24'(sw_y));
         hh_ff    <= hh;
      end
      if (en[2]) begin
         if (side2_ff.mode) begin
            foothold_out   <= '0;
            hip_height     <= '0;
            pivot_y        <= '0;
            swing_right    <= 1'b0;
            obstacle_y_out <= lft_pkg::sat_pos(oy_wide);
            obstacle_z_out <= side2_ff.obs_z;
         end else begin
            foothold_out   <= lft_pkg::sat_pos(fo_wide);
            hip_height     <= hh_ff;
            pivot_y        <= pivot_ff;
            swing_right    <= side2_ff.swing_right;
            obstacle_y_out <= '0;
            obstacle_z_out <= '0;
         end
      end
   end

endmodule
`default_nettype wire

### sv/leg_frame_translation_core.sv
// top level of the leg frame translation core: stream ports, csr registers, pipeline control
// depends on lft_pkg, lft_sine_lane and lft_merge
`default_nettype none
// Leg frame translation core. Each pose item feeds eight sine lanes (sine and cosine of the
// hip angle and of hip plus knee, for both legs), which place both heels by two-link
// forward kinematics; merging stages then give foothold and support heel relative to the
// swing heel, the hip height, and latch the y shift that obstacle items are moved by.
// Throughput is one item per clock unless the result side stalls; each item passes the
// nine-stage chain of each lane (angle fold, two-step reciprocal scale, squaring, four
// polynomial steps, length scale) plus three merge stages. Stalls on the result side ripple
// back only through full stages, so bubbles in the pipeline still take new items.
module leg_frame_translation_core (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0: left_hip_angle, left_knee_angle, right_hip_angle, right_knee_angle,
   // swing leg code, next_leg_right, foot_tip_y, foothold_y, obstacle_y, obstacle_z, zero pad
   input  wire logic [143:0] req_tdata,
   // tuser: mode
   input  wire logic         req_tuser,
   // response stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata from bit 0: foothold_out, hip_height, pivot_y, obstacle_y_out, obstacle_z_out,
   // swing_right
   output logic [87:0]       rsp_tdata,
   // register write channel
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [13:0]  csr_data
);

   localparam int NSTAGE = 12;

   // register file
   logic [13:0] thigh_ff, shin_ff;
   logic [12:0] foot_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thigh_ff <= lft_pkg::THIGH_RESET;
         shin_ff  <= lft_pkg::SHIN_RESET;
         foot_ff  <= lft_pkg::FOOT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lft_pkg::REG_THIGH: thigh_ff <= csr_data;
            lft_pkg::REG_SHIN:  shin_ff  <= csr_data;
            lft_pkg::REG_FOOT:  foot_ff  <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // input field unpacking
   logic signed [15:0] lh, lk, rh, rk;
   logic [1:0]         swing_code;
   logic               next_right;
   lft_pkg::side_type  side_in;
   logic signed [17:0] l_both, r_both;
   logic [7:0][17:0]   lane_angle;
   logic [7:0][13:0]   lane_len;

   always_comb begin
      lh         = req_tdata[15:0];
      lk         = req_tdata[31:16];
      rh         = req_tdata[47:32];
      rk         = req_tdata[63:48];
      swing_code = req_tdata[65:64];
      next_right = req_tdata[66];
      side_in.mode        = req_tuser;
      // unknown swing code (and the spare code) falls back to the next-leg bit
      side_in.swing_right = swing_code[1] ? next_right : swing_code[0];
      side_in.tip         = req_tdata[84:67];
      side_in.foothold    = req_tdata[102:85];
      side_in.obs_y       = req_tdata[120:103];
      side_in.obs_z       = req_tdata[138:121];
      l_both = 18'(lh) + 18'(lk);
      r_both = 18'(rh) + 18'(rk);
      // lanes 0-3 left leg, 4-7 right; cosine is sine a quarter turn on
      lane_angle[0] = 18'(lh);
      lane_angle[1] = l_both;
      lane_angle[2] = 18'(lh) + 18'sd9000;
      lane_angle[3] = l_both + 18'sd9000;
      lane_angle[4] = 18'(rh);
      lane_angle[5] = r_both;
      lane_angle[6] = 18'(rh) + 18'sd9000;
      lane_angle[7] = r_both + 18'sd9000;
      for (int i = 0; i < 8; i++) begin
         lane_len[i] = i[0] ? shin_ff : thigh_ff;
      end
   end

   // pipeline occupancy: a stage loads when it is empty or its contents move on
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] adv;

   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NSTAGE; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // item fields ride beside the lanes
   lft_pkg::side_type side_ff [9];

   always_ff @(posedge clock) begin
      if (adv[0]) side_ff[0] <= side_in;
      for (int k = 1; k < 9; k++) begin
         if (adv[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   logic [7:0][14:0] lane_proj;

   for (genvar g = 0; g < 8; g++) begin : g_lane
      lft_sine_lane u_lane (
         .clock    (clock),
         .en       (adv[8:0]),
         .angle    (lane_angle[g]),
         .link_len (lane_len[g]),
         .proj     (lane_proj[g])
      );
   end

   logic signed [17:0] foothold_out, pivot_y, obstacle_y_out, obstacle_z_out;
   logic [14:0]        hip_height;
   logic               swing_right;

   lft_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .en             (adv[11:9]),
      .m2_valid       (valid_ff[10]),
      .lane_proj      (lane_proj),
      .side           (side_ff[8]),
      .foot_len       (foot_ff),
      .foothold_out   (foothold_out),
      .hip_height     (hip_height),
      .pivot_y        (pivot_y),
      .obstacle_y_out (obstacle_y_out),
      .obstacle_z_out (obstacle_z_out),
      .swing_right    (swing_right)
   );

   assign rsp_tdata = {swing_right, obstacle_z_out, obstacle_y_out, pivot_y,
                       hip_height, foothold_out};

endmodule
`default_nettype wire
